// ===== src/swhs_pkg.sv =====
// swhs_pkg: phase codes, sequencer state type and fixed constants for the
// single-wire humidity sensor reader. No dependencies.
`timescale 1ns / 1ps

package swhs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_READY    = 3'd1,
    PH_TRIGGER  = 3'd2,
    PH_WAIT_ACK = 3'd3,
    PH_ACK_LOW  = 3'd4,
    PH_ACK_HIGH = 3'd5,
    PH_BIT_LOW  = 3'd6,
    PH_BIT_HIGH = 3'd7
  } phase_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_EVENT = 1'b1
  } kind_t;

  localparam int unsigned BYTES_PER_READING = 5;
  localparam int unsigned BITS_PER_BYTE     = 8;
  localparam int unsigned FRAME_BITS        = BYTES_PER_READING * BITS_PER_BYTE;
  localparam logic [15:0] THRESHOLD_RESET   = 16'd750;
  localparam logic [7:0]  SIGN_MASK         = 8'h80;
  localparam logic [7:0]  MAG_MASK          = 8'h7f;

  typedef struct packed {
    phase_t                  phase;
    logic [FRAME_BITS-1:0]   received_bits;
  } seq_state_t;

endpackage

// ===== src/swhs_in_stage.sv =====
// swhs_in_stage: input register for event transfers.
// Depends on swhs_pkg.
`timescale 1ns / 1ps

module swhs_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 kind,
  input  logic [15:0]          pulse_ticks,
  input  logic                 advance,
  output logic                 held_valid,
  output swhs_pkg::kind_t      held_kind,
  output logic [15:0]          held_ticks
);

  logic take;

  assign item_stall = held_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_kind  <= swhs_pkg::kind_t'(kind);
      held_ticks <= pulse_ticks;
    end
  end

endmodule

// ===== src/swhs_seq.sv =====
// swhs_seq: phase sequencer, bit counters and 40-bit receive shift store.
// Depends on swhs_pkg.
`timescale 1ns / 1ps

module swhs_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  swhs_pkg::kind_t       held_kind,
  input  logic [15:0]           held_ticks,
  input  logic [15:0]           threshold,
  output swhs_pkg::seq_state_t  state_next
);

  swhs_pkg::phase_t                      current_phase, current_phase_next;
  logic [2:0]                            bit_in_byte, bit_in_byte_next;
  logic [2:0]                            byte_index, byte_index_next;
  logic [swhs_pkg::FRAME_BITS-1:0]       received_bits, received_bits_next;
  logic                                  bit_value;

  assign bit_value = held_ticks > threshold;

  always_comb begin
    current_phase_next = current_phase;
    bit_in_byte_next   = bit_in_byte;
    byte_index_next    = byte_index;
    received_bits_next = received_bits;
    if (held_kind == swhs_pkg::KIND_START) begin
      current_phase_next = swhs_pkg::PH_TRIGGER;
    end else begin
      unique case (current_phase)
        swhs_pkg::PH_TRIGGER:  current_phase_next = swhs_pkg::PH_WAIT_ACK;
        swhs_pkg::PH_WAIT_ACK: current_phase_next = swhs_pkg::PH_ACK_LOW;
        swhs_pkg::PH_ACK_LOW: begin
          current_phase_next = swhs_pkg::PH_ACK_HIGH;
          bit_in_byte_next   = '0;
          byte_index_next    = '0;
        end
        swhs_pkg::PH_ACK_HIGH: current_phase_next = swhs_pkg::PH_BIT_LOW;
        swhs_pkg::PH_BIT_LOW:  current_phase_next = swhs_pkg::PH_BIT_HIGH;
        swhs_pkg::PH_BIT_HIGH: begin
          received_bits_next = {received_bits[swhs_pkg::FRAME_BITS-2:0], bit_value};
          bit_in_byte_next   = bit_in_byte + 3'd1;
          if (bit_in_byte_next == 3'd0) begin
            byte_index_next = byte_index + 3'd1;
          end
          current_phase_next = (byte_index_next >= 3'(swhs_pkg::BYTES_PER_READING))
                               ? swhs_pkg::PH_READY : swhs_pkg::PH_BIT_LOW;
        end
        swhs_pkg::PH_IDLE, swhs_pkg::PH_READY: current_phase_next = current_phase;
        default: current_phase_next = current_phase;
      endcase
    end
  end

  assign state_next.phase         = current_phase_next;
  assign state_next.received_bits = received_bits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_phase <= swhs_pkg::PH_IDLE;
      bit_in_byte   <= '0;
      byte_index    <= '0;
      received_bits <= '0;
    end else if (fire) begin
      current_phase <= current_phase_next;
      bit_in_byte   <= bit_in_byte_next;
      byte_index    <= byte_index_next;
      received_bits <= received_bits_next;
    end
  end

endmodule

// ===== src/swhs_result.sv =====
// swhs_result: decodes the post-transfer state into line controls and
// reading fields, and holds them in the result register. Depends on swhs_pkg.
`timescale 1ns / 1ps

module swhs_result (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  swhs_pkg::seq_state_t  state_next,
  output logic                  advance,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [2:0]            phase,
  output logic                  line_low,
  output logic                  arm_rising,
  output logic                  reading_ready,
  output logic [15:0]           humidity,
  output logic signed [15:0]    temperature,
  output logic [7:0]            check_byte
);

  logic        ready;
  logic [7:0]  byte0, byte1, byte2, byte3, byte4;
  logic [15:0] mag;
  logic [15:0] hum_c, temp_c;
  logic [7:0]  chk_c;

  assign advance = !result_valid || !result_stall;

  assign byte0 = state_next.received_bits[39:32];
  assign byte1 = state_next.received_bits[31:24];
  assign byte2 = state_next.received_bits[23:16];
  assign byte3 = state_next.received_bits[15:8];
  assign byte4 = state_next.received_bits[7:0];

  always_comb begin
    ready  = state_next.phase == swhs_pkg::PH_READY;
    mag    = {1'b0, byte2[6:0] & swhs_pkg::MAG_MASK[6:0], byte3};
    hum_c  = '0;
    temp_c = '0;
    chk_c  = '0;
    if (ready) begin
      hum_c  = {byte0, byte1};
      temp_c = ((byte2 & swhs_pkg::SIGN_MASK) != 8'd0) ? 16'(16'd0 - mag) : mag;
      chk_c  = byte4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      phase         <= state_next.phase;
      line_low      <= state_next.phase == swhs_pkg::PH_TRIGGER;
      arm_rising    <= state_next.phase == swhs_pkg::PH_ACK_LOW ||
                       state_next.phase == swhs_pkg::PH_BIT_LOW;
      reading_ready <= ready;
      humidity      <= hum_c;
      temperature   <= signed'(temp_c);
      check_byte    <= chk_c;
    end
  end

endmodule

// ===== src/single_wire_humidity_sensor_reader.sv =====
// single_wire_humidity_sensor_reader: top level of the sensor receive sequencer.
// Depends on swhs_pkg, swhs_in_stage, swhs_seq, swhs_result.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   item     | item_valid / item_stall    | kind, pulse_ticks
//   result   | result_valid / result_stall| phase, line_low, arm_rising,
//            |                            | reading_ready, humidity, temperature,
//            |                            | check_byte
//   cfg      | cfg_valid / cfg_ready      | cfg_data (one_bit_threshold)
//
// One transfer per cycle while result_stall allows it; an item is held in the input
// register, and its result is then loaded into the result register.
// Synchronous reset returns to idle with an empty frame and threshold 750.
// Result stall holds the result register and backs up into the input register;
// cfg_ready is always high.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic [15:0]        pulse_ticks,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         phase,
  output logic               line_low,
  output logic               arm_rising,
  output logic               reading_ready,
  output logic [15:0]        humidity,
  output logic signed [15:0] temperature,
  output logic [7:0]         check_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic                 advance;
  logic                 held_valid;
  swhs_pkg::kind_t      held_kind;
  logic [15:0]          held_ticks;
  logic                 fire;
  logic [15:0]          threshold;
  swhs_pkg::seq_state_t state_next;

  assign cfg_ready = 1'b1;
  assign fire      = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= swhs_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  swhs_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .pulse_ticks (pulse_ticks),
    .advance     (advance),
    .held_valid  (held_valid),
    .held_kind   (held_kind),
    .held_ticks  (held_ticks)
  );

  swhs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .held_kind  (held_kind),
    .held_ticks (held_ticks),
    .threshold  (threshold),
    .state_next (state_next)
  );

  swhs_result u_res (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .state_next    (state_next),
    .advance       (advance),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .phase         (phase),
    .line_low      (line_low),
    .arm_rising    (arm_rising),
    .reading_ready (reading_ready),
    .humidity      (humidity),
    .temperature   (temperature),
    .check_byte    (check_byte)
  );

endmodule

// ===== src/swhs_checker.sv =====
// swhs_checker: port-level assertions for the sensor reader, bound to the top.
// Depends on swhs_pkg and single_wire_humidity_sensor_reader.
`timescale 1ns / 1ps

module swhs_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input logic [2:0]         phase,
  input logic               line_low,
  input logic               arm_rising,
  input logic               reading_ready,
  input logic [15:0]        humidity,
  input logic signed [15:0] temperature,
  input logic [7:0]         check_byte
);

  a_line_low: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (line_low == (phase == swhs_pkg::PH_TRIGGER)))
    else $error("line_low disagrees with phase");

  a_arm: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (arm_rising == (phase == swhs_pkg::PH_ACK_LOW ||
                                     phase == swhs_pkg::PH_BIT_LOW)))
    else $error("arm_rising disagrees with phase");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !reading_ready) |->
      (humidity == 16'd0 && temperature == 16'sd0 && check_byte == 8'd0))
    else $error("reading fields non-zero outside ready");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(phase) && $stable(humidity) && $stable(temperature)))
    else $error("stalled result changed");

endmodule

bind single_wire_humidity_sensor_reader swhs_checker u_swhs_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .phase         (phase),
  .line_low      (line_low),
  .arm_rising    (arm_rising),
  .reading_ready (reading_ready),
  .humidity      (humidity),
  .temperature   (temperature),
  .check_byte    (check_byte)
);

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for single_wire_humidity_sensor_reader.
// Holds its own phase and frame tracker, drives readings and noise through the
// item channel, and compares every result transfer. Depends on swhs_pkg.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    swhs_pkg::phase_t   phase;
    logic               line_low;
    logic               arm_rising;
    logic               reading_ready;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
    logic [7:0]         check_byte;
  } sensor_result_t;

  class phase_tracker;
    sensor_result_t                  expected_results[$];
    swhs_pkg::phase_t                ph;
    logic [2:0]                      bit_cnt;
    logic [2:0]                      byte_cnt;
    logic [swhs_pkg::FRAME_BITS-1:0] frame;
    logic [15:0]                     threshold;
    int unsigned                     mismatches;
    int unsigned                     readings_seen;

    function new();
      ph            = swhs_pkg::PH_IDLE;
      bit_cnt       = '0;
      byte_cnt      = '0;
      frame         = '0;
      threshold     = swhs_pkg::THRESHOLD_RESET;
      mismatches    = 0;
      readings_seen = 0;
    endfunction

    // advance the sequencer by one accepted item and queue the result it gives
    function void note_item(swhs_pkg::kind_t k, logic [15:0] ticks);
      sensor_result_t r;
      logic [15:0]    mag;
      if (k == swhs_pkg::KIND_START) begin
        ph = swhs_pkg::PH_TRIGGER;
      end else begin
        case (ph)
          swhs_pkg::PH_TRIGGER:  ph = swhs_pkg::PH_WAIT_ACK;
          swhs_pkg::PH_WAIT_ACK: ph = swhs_pkg::PH_ACK_LOW;
          swhs_pkg::PH_ACK_LOW: begin
            ph       = swhs_pkg::PH_ACK_HIGH;
            bit_cnt  = '0;
            byte_cnt = '0;
          end
          swhs_pkg::PH_ACK_HIGH: ph = swhs_pkg::PH_BIT_LOW;
          swhs_pkg::PH_BIT_LOW:  ph = swhs_pkg::PH_BIT_HIGH;
          swhs_pkg::PH_BIT_HIGH: begin
            frame   = {frame[swhs_pkg::FRAME_BITS-2:0], ticks > threshold};
            bit_cnt = bit_cnt + 3'd1;
            if (bit_cnt == 3'd0) byte_cnt = byte_cnt + 3'd1;
            ph = (byte_cnt >= swhs_pkg::BYTES_PER_READING) ? swhs_pkg::PH_READY
                                                            : swhs_pkg::PH_BIT_LOW;
          end
          default: ;
        endcase
      end
      r               = '0;
      r.phase         = ph;
      r.line_low      = (ph == swhs_pkg::PH_TRIGGER);
      r.arm_rising    = (ph == swhs_pkg::PH_ACK_LOW) || (ph == swhs_pkg::PH_BIT_LOW);
      r.reading_ready = (ph == swhs_pkg::PH_READY);
      if (r.reading_ready) begin
        mag           = {(frame[23:16] & swhs_pkg::MAG_MASK), frame[15:8]};
        r.humidity    = frame[39:24];
        r.temperature = ((frame[23:16] & swhs_pkg::SIGN_MASK) != 8'h00)
                        ? 16'(16'd0 - mag) : mag;
        r.check_byte  = frame[7:0];
      end
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 30) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_result(sensor_result_t got);
      sensor_result_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("result transfer with nothing expected, phase %0d", got.phase));
      end else begin
        exp = expected_results.pop_front();
        if (got.reading_ready === 1'b1) readings_seen++;
        if (got.phase !== exp.phase)
          report($sformatf("phase %0d, want %0d", got.phase, exp.phase));
        if (got.line_low !== exp.line_low)
          report($sformatf("line_low %b, want %b", got.line_low, exp.line_low));
        if (got.arm_rising !== exp.arm_rising)
          report($sformatf("arm_rising %b, want %b", got.arm_rising, exp.arm_rising));
        if (got.reading_ready !== exp.reading_ready)
          report($sformatf("reading_ready %b, want %b", got.reading_ready,
                           exp.reading_ready));
        if (got.humidity !== exp.humidity)
          report($sformatf("humidity %h, want %h", got.humidity, exp.humidity));
        if (got.temperature !== exp.temperature)
          report($sformatf("temperature %0d, want %0d", got.temperature, exp.temperature));
        if (got.check_byte !== exp.check_byte)
          report($sformatf("check_byte %h, want %h", got.check_byte, exp.check_byte));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic               kind;
  logic [15:0]        pulse_ticks;
  logic               result_valid;
  logic               result_stall;
  logic [2:0]         phase;
  logic               line_low;
  logic               arm_rising;
  logic               reading_ready;
  logic [15:0]        humidity;
  logic signed [15:0] temperature;
  logic [7:0]         check_byte;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  phase_tracker tracker = new();
  int unsigned  idle_pct  = 0;
  int unsigned  stall_pct = 0;
  int unsigned  cur_thr   = swhs_pkg::THRESHOLD_RESET;
  int unsigned  items_sent = 0;
  int unsigned  rand_thr;

  single_wire_humidity_sensor_reader i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .pulse_ticks   (pulse_ticks),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .phase         (phase),
    .line_low      (line_low),
    .arm_rising    (arm_rising),
    .reading_ready (reading_ready),
    .humidity      (humidity),
    .temperature   (temperature),
    .check_byte    (check_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      tracker.note_item(swhs_pkg::kind_t'(kind), pulse_ticks);
  end

  always @(posedge clk) begin : result_side
    sensor_result_t got;
    if (!rst && result_valid && !result_stall) begin
      got.phase         = swhs_pkg::phase_t'(phase);
      got.line_low      = line_low;
      got.arm_rising    = arm_rising;
      got.reading_ready = reading_ready;
      got.humidity      = humidity;
      got.temperature   = temperature;
      got.check_byte    = check_byte;
      tracker.check_result(got);
    end
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // one item transfer, with a random gap before it
  task automatic send_item(input swhs_pkg::kind_t k, input logic [15:0] t);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    pulse_ticks <= t;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  function automatic logic [15:0] pulse_for(input bit one, input bit extremes);
    if (extremes) return one ? 16'hffff : 16'h0000;
    if (one) begin
      if (cur_thr >= 32'hffff) return 16'($urandom);
      return $urandom_range(1) ? 16'(cur_thr + 1) : 16'($urandom_range(32'hffff, cur_thr + 1));
    end
    return $urandom_range(1) ? 16'(cur_thr) : 16'($urandom_range(cur_thr, 0));
  endfunction

  // start, handshake events, then nbits of the frame (fewer than 40 abandons it)
  task automatic send_reading(input logic [39:0] bits, input int nbits, input bit extremes);
    send_item(swhs_pkg::KIND_START, 16'($urandom));
    repeat (4) send_item(swhs_pkg::KIND_EVENT, 16'($urandom));
    for (int i = 39; i >= 40 - nbits; i--) begin
      send_item(swhs_pkg::KIND_EVENT, 16'($urandom));
      send_item(swhs_pkg::KIND_EVENT, pulse_for(bits[i], extremes));
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_item(swhs_pkg::kind_t'($urandom_range(1)), 16'($urandom));
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.threshold = v;
    cur_thr = v;
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_reading({8'($urandom), 32'($urandom)}, 40, 1'b0);
        if ($urandom_range(1)) send_noise($urandom_range(3, 1));
      end else if (pick < 85) begin
        send_reading({8'($urandom), 32'($urandom)}, $urandom_range(39, 0), 1'b0);
      end else begin
        send_noise($urandom_range(8, 1));
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    kind         <= swhs_pkg::KIND_START;
    pulse_ticks  <= 16'h0000;
    result_stall <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= 16'h0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // events while idle leave the phase at idle
    send_item(swhs_pkg::KIND_EVENT, 16'h0000);
    send_item(swhs_pkg::KIND_EVENT, 16'hffff);
    // restart from trigger and from ack low
    send_item(swhs_pkg::KIND_START, 16'h0000);
    send_item(swhs_pkg::KIND_START, 16'hffff);
    send_item(swhs_pkg::KIND_EVENT, 16'h0000);
    send_item(swhs_pkg::KIND_EVENT, 16'h0000);
    send_item(swhs_pkg::KIND_START, 16'h0000);
    send_reading(40'h01_f4_80_65_5a, 40, 1'b0);
    send_item(swhs_pkg::KIND_EVENT, 16'hffff);
    send_item(swhs_pkg::KIND_EVENT, 16'h0000);
    send_reading(40'h00_00_80_00_80, 40, 1'b0);
    send_reading(40'hff_ff_ff_ff_ff, 40, 1'b1);
    send_reading(40'h00_00_00_00_00, 40, 1'b1);
    send_reading(40'h7f_ff_7f_ff_ff, 13, 1'b0);
    send_reading(40'h12_34_7f_ff_c3, 40, 1'b0);

    write_threshold(16'h0000);
    idle_pct = 0; stall_pct = 0;
    random_phase(85);

    write_threshold(16'hffff);
    idle_pct = 68; stall_pct = 0;
    random_phase(85);

    rand_thr = $urandom_range(16'hffff);
    write_threshold(16'(rand_thr));
    idle_pct = 0; stall_pct = 68;
    random_phase(85);

    write_threshold(16'h0001);
    idle_pct = 9; stall_pct = 9;
    random_phase(85);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d items, %0d ready results seen, %0d mismatches.",
             items_sent, tracker.readings_seen, tracker.mismatches);
    $display("Thresholds 750, 0, 65535, %0d and 1 under four idle and stall mixes.", rand_thr);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding.", tracker.expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/swhs_pkg.sv
src/swhs_in_stage.sv
src/swhs_seq.sv
src/swhs_result.sv
src/single_wire_humidity_sensor_reader.sv
src/swhs_checker.sv
verif/tb_top.sv
